>>> sv/rdx4_pkg.sv
package rdx4_pkg;

    typedef struct packed {
        logic signed [15:0] im;
        logic signed [15:0] re;
    } t_cplx;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } t_twid;

    typedef struct packed {
        logic en;
    } t_pipe_ctl;

    localparam logic signed [15:0] C_MAX16 = 16'sh7FFF;
    localparam logic signed [15:0] C_MIN16 = 16'sh8000;

    function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767) begin
            r = C_MAX16;
        end else if (v < -17'sd32768) begin
            r = C_MIN16;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        s = 17'(a) + 17'(b);
        return sat17(s);
    endfunction

    function automatic logic signed [15:0] sat_sub(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        s = 17'(a) - 17'(b);
        return sat17(s);
    endfunction

    function automatic logic signed [15:0] wrap_neg(input logic signed [15:0] a);
        logic signed [15:0] r;
        r = 16'sd0 - a;
        return r;
    endfunction

endpackage

>>> sv/rdx4_front.sv
module rdx4_front (
    input  logic                 i_clk,
    input  rdx4_pkg::t_pipe_ctl  i_ctl,
    input  rdx4_pkg::t_cplx      i_x0,
    input  rdx4_pkg::t_cplx      i_x1,
    input  rdx4_pkg::t_cplx      i_x2,
    input  rdx4_pkg::t_cplx      i_x3,
    output rdx4_pkg::t_cplx      o_p0,
    output rdx4_pkg::t_cplx      o_p1,
    output rdx4_pkg::t_cplx      o_p2,
    output rdx4_pkg::t_cplx      o_p3
);
    import rdx4_pkg::*;

    t_cplx r_a, r_b, r_c, r_d;
    t_cplx n_a, n_b, n_c, n_d;
    t_cplx r_p0, r_p1, r_p2, r_p3;
    t_cplx n_p0, n_p1, n_p2, n_p3;
    t_cplx jd;

    always_comb begin
        n_a.re = sat_add(i_x0.re, i_x2.re);
        n_a.im = sat_add(i_x0.im, i_x2.im);
        n_c.re = sat_add(i_x1.re, i_x3.re);
        n_c.im = sat_add(i_x1.im, i_x3.im);
        n_b.re = sat_sub(i_x0.re, i_x2.re);
        n_b.im = sat_sub(i_x0.im, i_x2.im);
        n_d.re = sat_sub(i_x1.re, i_x3.re);
        n_d.im = sat_sub(i_x1.im, i_x3.im);
    end

    always_comb begin
        jd.re   = wrap_neg(r_d.im);
        jd.im   = r_d.re;
        n_p0.re = sat_add(r_a.re, r_c.re) >>> 1;
        n_p0.im = sat_add(r_a.im, r_c.im) >>> 1;
        n_p1.re = sat_sub(r_b.re, jd.re);
        n_p1.im = sat_sub(r_b.im, jd.im);
        n_p2.re = sat_sub(r_a.re, r_c.re);
        n_p2.im = sat_sub(r_a.im, r_c.im);
        n_p3.re = sat_add(r_b.re, jd.re);
        n_p3.im = sat_add(r_b.im, jd.im);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a  <= n_a;
            r_b  <= n_b;
            r_c  <= n_c;
            r_d  <= n_d;
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;
        end
    end

    assign o_p0 = r_p0;
    assign o_p1 = r_p1;
    assign o_p2 = r_p2;
    assign o_p3 = r_p3;

endmodule

>>> sv/rdx4_cmul.sv
module rdx4_cmul (
    input  logic                 i_clk,
    input  rdx4_pkg::t_pipe_ctl  i_ctl,
    input  rdx4_pkg::t_cplx      i_z,
    input  rdx4_pkg::t_twid      i_w,
    output rdx4_pkg::t_cplx      o_y
);
    import rdx4_pkg::*;

    logic signed [31:0] r_rr, r_in, r_ri, r_ir;
    logic signed [31:0] n_rr, n_in, n_ri, n_ir;
    logic signed [31:0] sum_re, sum_im;
    t_cplx              r_y;
    t_cplx              n_y;

    always_comb begin
        n_rr = 32'(i_z.re * i_w.re);
        n_in = 32'(i_z.im * wrap_neg(i_w.im));
        n_ri = 32'(i_z.re * i_w.im);
        n_ir = 32'(i_z.im * i_w.re);
    end

    always_comb begin
        sum_re = r_rr + r_in;
        sum_im = r_ri + r_ir;
        n_y.re = sum_re[31:16];
        n_y.im = sum_im[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rr <= n_rr;
            r_in <= n_in;
            r_ri <= n_ri;
            r_ir <= n_ir;
            r_y  <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

>>> sv/radix4_dif_butterfly_q15_unit.sv
// Radix-4 decimation-in-frequency butterfly on Q15 complex samples. Each item carries four
// samples and three twiddles and passes four register stages before its result is presented:
// two stages of saturating sums and differences, one stage of 16x16 products and one stage that
// adds product pairs and keeps the upper halves. A new item is taken in every cycle; the whole
// pipeline holds while a waiting result is stalled.
module radix4_dif_butterfly_q15_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_x0,
    input  logic [31:0] i_x1,
    input  logic [31:0] i_x2,
    input  logic [31:0] i_x3,
    input  logic [31:0] i_w1,
    input  logic [31:0] i_w2,
    input  logic [31:0] i_w3,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_y0,
    output logic [31:0] o_y1,
    output logic [31:0] o_y2,
    output logic [31:0] o_y3
);
    import rdx4_pkg::*;

    localparam int unsigned C_DEPTH = 4;

    t_pipe_ctl            ctl;
    logic [C_DEPTH-1:0]   r_vld;
    logic [C_DEPTH-1:0]   n_vld;
    t_twid                r_w_s1 [3];
    t_twid                r_w_s2 [3];
    t_cplx                r_y0_s3, r_y0_s4;
    t_cplx                p0, p1, p2, p3;
    t_cplx                y1, y2, y3;

    assign ctl.en  = !(r_vld[C_DEPTH-1] && i_stall);
    assign o_stall = !ctl.en;
    assign n_vld   = {r_vld[C_DEPTH-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ctl.en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en) begin
            r_w_s1[0] <= i_w1;
            r_w_s1[1] <= i_w2;
            r_w_s1[2] <= i_w3;
            r_w_s2    <= r_w_s1;
            r_y0_s3   <= p0;
            r_y0_s4   <= r_y0_s3;
        end
    end

    rdx4_front u_front (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_x0  (i_x0),
        .i_x1  (i_x1),
        .i_x2  (i_x2),
        .i_x3  (i_x3),
        .o_p0  (p0),
        .o_p1  (p1),
        .o_p2  (p2),
        .o_p3  (p3)
    );

    rdx4_cmul u_cmul1 (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_z   (p1),
        .i_w   (r_w_s2[0]),
        .o_y   (y1)
    );

    rdx4_cmul u_cmul2 (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_z   (p2),
        .i_w   (r_w_s2[1]),
        .o_y   (y2)
    );

    rdx4_cmul u_cmul3 (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_z   (p3),
        .i_w   (r_w_s2[2]),
        .o_y   (y3)
    );

    assign o_valid = r_vld[C_DEPTH-1];
    assign o_y0    = r_y0_s4;
    assign o_y1    = y1;
    assign o_y2    = y2;
    assign o_y3    = y3;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item did not enter the first stage");

    a_last_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && r_vld[C_DEPTH-2]) |=> o_valid)
        else $error("item lost between the product and output stages");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_vld == $past(r_vld)))
        else $error("pipeline valid bits changed while held");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input held back while the output was free");

endmodule
